/* rtl/pst_pkg.sv */
// Shared types and codes for the periodic task scheduler.
package pst_pkg;

  localparam int SLOT_W   = 8;
  localparam int PERIOD_W = 15;
  localparam int INDEX_W  = 6;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_ADD      = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_SLOT_RANGE  = 2'd1;
  localparam logic [1:0] ST_ZERO_PERIOD = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                handler_present;
  } req_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] task_index;
    logic               found;
    logic [1:0]         status;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_SCAN,
    S_APPLY,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic scan;
    logic apply;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       scan_hit;
    logic       scan_last;
    logic       tick_done;
    logic       out_free;
  } dp_sts_t;

endpackage

/* rtl/periodic_task_scheduler.sv */
// Periodic task scheduler: NUM_TASKS slots of period, countdown, ready and handler flags.
//
// Request channel req_valid/req_ready/req carries one item: tick, dispatch, add or clear.
// Response channel rsp_valid/rsp_ready/rsp returns exactly one item per request,
// in order: task_index, found and status.
// One request is worked at a time; req_ready is high only while the sequencer idles.
// The sequencer steps each request through its own states:
//   tick      all NUM_TASKS slots, one slot per cycle through the countdown memory read port
//   dispatch  at most NUM_TASKS slots up to the first hit, one flag pair per cycle
//   add/clear the addressed slot is updated in the apply state
// Between requests the sequencer returns to the idle state.
// The result sits in an output register; if the receiver stalls, the next request
// is still accepted and worked, and its result waits until the register frees.
// Reset (rst, synchronous) clears all ready, handler and in-use flags and empties
// the output register; slot periods and countdowns need no clearing since an
// unused slot is never read back.
module periodic_task_scheduler import pst_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pst_datapath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/pst_ctrl.sv */
// Sequencer: decodes each item and steps the datapath through its slot walk or slot update.
module pst_ctrl import pst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (sts.in_op)
            OP_TICK:     state_next = S_TICK;
            OP_DISPATCH: state_next = S_SCAN;
            default:     state_next = S_APPLY;
          endcase
        end
      end
      S_TICK: begin
        if (sts.tick_done) begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit || sts.scan_last) begin
          state_next = S_FINISH;
        end
      end
      S_APPLY:  state_next = S_FINISH;
      S_FINISH: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_TICK:   cmd.tick     = 1'b1;
      S_SCAN:   cmd.scan     = 1'b1;
      S_APPLY:  cmd.apply    = 1'b1;
      S_FINISH: cmd.out_load = sts.out_free;
      default:  cmd          = '0;
    endcase
  end

endmodule

/* rtl/pst_datapath.sv */
// Slot table, countdown memory, walk counter and result register.
module pst_datapath import pst_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  req_item_t req,
  output rsp_item_t rsp,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int MW = 2 * PERIOD_W;

  // latched item
  logic [1:0]          cur_op;
  logic [SLOT_W-1:0]   cur_slot;
  logic [PERIOD_W-1:0] cur_period;
  logic                cur_hp;

  // per-slot flags; live marks a slot that was ever added (countdown nonzero)
  logic [NUM_TASKS-1:0] slot_ready;
  logic [NUM_TASKS-1:0] slot_has_handler;
  logic [NUM_TASKS-1:0] slot_live;

  // {period, countdown} per slot
  logic [MW-1:0] slot_mem [NUM_TASKS];
  logic [MW-1:0] rd_data;

  logic [CW-1:0] cnt;
  logic [IW-1:0] cnt_idx;
  logic          pend;
  logic [IW-1:0] pend_idx;

  logic [IW-1:0] res_idx;
  logic          res_found;
  logic [1:0]    res_status;

  logic                slot_ok;
  logic [IW-1:0]       slot_idx;
  logic                add_ok;
  logic                clear_ok;
  logic [PERIOD_W-1:0] rd_cd;
  logic [PERIOD_W-1:0] rd_per;
  logic [PERIOD_W-1:0] cd_dec;
  logic                reload;
  logic                wb_en;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [MW-1:0]       mem_wdata;
  logic                scan_hit;
  logic                cnt_end;

  assign cnt_idx  = cnt[IW-1:0];
  assign cnt_end  = (cnt == CW'(NUM_TASKS));
  assign slot_ok  = (cur_slot < SLOT_W'(NUM_TASKS));
  assign slot_idx = cur_slot[IW-1:0];
  assign add_ok   = cmd.apply && (cur_op == OP_ADD) && slot_ok && (cur_period != '0);
  assign clear_ok = cmd.apply && (cur_op == OP_CLEAR) && slot_ok;

  assign rd_cd  = rd_data[PERIOD_W-1:0];
  assign rd_per = rd_data[MW-1:PERIOD_W];
  assign cd_dec = rd_cd - PERIOD_W'(1);
  assign reload = (cd_dec == '0);
  assign wb_en  = cmd.tick && pend && slot_live[pend_idx];

  assign scan_hit = cmd.scan && slot_ready[cnt_idx] && slot_has_handler[cnt_idx];

  always_comb begin
    mem_we    = wb_en || add_ok;
    mem_waddr = add_ok ? slot_idx : pend_idx;
    if (add_ok) begin
      mem_wdata = {cur_period, cur_period};
    end else begin
      mem_wdata = {rd_per, reload ? rd_per : cd_dec};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= slot_mem[cnt_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_op     <= req.operation;
      cur_slot   <= req.slot;
      cur_period <= req.period;
      cur_hp     <= req.handler_present;
    end
  end

  // walk counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.load) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cmd.tick) begin
      pend <= !cnt_end;
      if (!cnt_end) begin
        cnt <= cnt + CW'(1);
      end
    end else if (cmd.scan) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= cnt_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ready       <= '0;
      slot_has_handler <= '0;
      slot_live        <= '0;
    end else begin
      if (wb_en && reload) begin
        slot_ready[pend_idx] <= 1'b1;
      end
      if (scan_hit) begin
        slot_ready[cnt_idx] <= 1'b0;
      end
      if (add_ok) begin
        slot_ready[slot_idx]       <= 1'b0;
        slot_has_handler[slot_idx] <= cur_hp;
        slot_live[slot_idx]        <= 1'b1;
      end
      if (clear_ok) begin
        slot_ready[slot_idx]       <= 1'b0;
        slot_has_handler[slot_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_idx    <= '0;
      res_found  <= 1'b0;
      res_status <= ST_OK;
    end else begin
      if (scan_hit) begin
        res_idx   <= cnt_idx;
        res_found <= 1'b1;
      end
      if (cmd.apply && !slot_ok) begin
        res_status <= ST_SLOT_RANGE;
      end else if (cmd.apply && (cur_op == OP_ADD) && (cur_period == '0)) begin
        res_status <= ST_ZERO_PERIOD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.task_index <= INDEX_W'(res_idx);
      rsp.found      <= res_found;
      rsp.status     <= res_status;
    end
  end

  always_comb begin
    sts.in_op     = req.operation;
    sts.scan_hit  = scan_hit;
    sts.scan_last = (cnt_idx == IW'(NUM_TASKS - 1));
    sts.tick_done = pend && (pend_idx == IW'(NUM_TASKS - 1));
    sts.out_free  = !rsp_valid || rsp_ready;
  end

endmodule

/* verif/tb.sv */
// Self-checking testbench for the periodic task scheduler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pst_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  periodic_task_scheduler #(.NUM_TASKS(NUM_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Scheduler state as the block should hold it
  logic [PERIOD_W-1:0] task_period    [NUM_SLOTS];
  logic [PERIOD_W-1:0] task_countdown [NUM_SLOTS];
  bit                  task_ready     [NUM_SLOTS];
  bit                  task_handler   [NUM_SLOTS];

  rsp_item_t pending_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        pattern_left = 0;
  int        ready_pct = 100;
  bit        hold_req = 1'b0;
  logic      hold_off = 1'b0;

  initial begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      task_period[k]    = '0;
      task_countdown[k] = '0;
      task_ready[k]     = 1'b0;
      task_handler[k]   = 1'b0;
    end
  end

  // Applies one item to the scheduler state and returns its result
  function automatic rsp_item_t schedule_step(req_item_t item);
    rsp_item_t r;
    int        hit;
    r   = '0;
    hit = -1;
    r.status = ST_OK;
    case (item.operation)
      OP_TICK: begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          // a zero countdown marks a slot that was never added
          if (task_countdown[k] != '0) begin
            task_countdown[k] = task_countdown[k] - PERIOD_W'(1);
            if (task_countdown[k] == '0) begin
              task_countdown[k] = task_period[k];
              task_ready[k]     = 1'b1;
            end
          end
        end
      end
      OP_DISPATCH: begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (hit < 0 && task_ready[k] && task_handler[k]) hit = k;
        end
        if (hit >= 0) begin
          task_ready[hit] = 1'b0;
          r.task_index    = hit[INDEX_W-1:0];
          r.found         = 1'b1;
        end
      end
      OP_ADD: begin
        if (item.slot >= NUM_SLOTS) begin
          r.status = ST_SLOT_RANGE;
        end else if (item.period == '0) begin
          r.status = ST_ZERO_PERIOD;
        end else begin
          task_period[item.slot]    = item.period;
          task_countdown[item.slot] = item.period;
          task_ready[item.slot]     = 1'b0;
          task_handler[item.slot]   = item.handler_present;
        end
      end
      default: begin
        if (item.slot >= NUM_SLOTS) begin
          r.status = ST_SLOT_RANGE;
        end else begin
          task_handler[item.slot] = 1'b0;
          task_ready[item.slot]   = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, rsp_item_t want, rsp_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch %s at cycle %0d: expected idx=%0d found=%0d st=%0d,",
               what, cycle_count, want.task_index, want.found, want.status);
      $display("  got idx=%0d found=%0d st=%0d", got.task_index, got.found, got.status);
    end
  endtask

  // Predict on request accept, check on response accept
  always @(posedge clk) begin
    rsp_item_t want;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (req_valid && req_ready) pending_results.push_back(schedule_step(req));
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", '0, rsp);
        end else begin
          want = pending_results.pop_front();
          if (rsp.task_index != want.task_index) report_mismatch("task_index", want, rsp);
          if (rsp.found != want.found) report_mismatch("found", want, rsp);
          if (rsp.status != want.status) report_mismatch("status", want, rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver: random ready whose rate is redrawn whenever a pattern counter runs out
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_left <= $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 70;
        2: ready_pct <= 35;
        default: ready_pct <= 10;
      endcase
    end else begin
      pattern_left <= pattern_left - 1;
    end
    rsp_ready <= !hold_off && ($urandom_range(0, 99) < ready_pct);
  end

  // Long receiver hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
      end
    end
  end

  function automatic req_item_t make_item(logic [1:0] op, int slot, int period, bit hp);
    req_item_t item;
    item.operation       = op;
    item.slot            = slot[SLOT_W-1:0];
    item.period          = period[PERIOD_W-1:0];
    item.handler_present = hp;
    return item;
  endfunction

  function automatic req_item_t random_item();
    req_item_t item;
    int        pick;
    item.operation       = OP_TICK;
    item.slot            = SLOT_W'($urandom_range(0, 255));
    item.period          = PERIOD_W'($urandom_range(0, 32767));
    item.handler_present = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      item.operation = OP_TICK;
    end else if (pick < 62) begin
      item.operation = OP_DISPATCH;
    end else if (pick < 86) begin
      item.operation = OP_ADD;
      if ($urandom_range(0, 9) != 0) item.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
      pick = $urandom_range(0, 99);
      // short periods so that slots come due often
      if (pick < 80) item.period = PERIOD_W'($urandom_range(1, 6));
      else if (pick < 88) item.period = '0;
      item.handler_present = ($urandom_range(0, 4) != 0);
    end else begin
      item.operation = OP_CLEAR;
      if ($urandom_range(0, 9) != 0) item.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    end
    return item;
  endfunction

  // Sender: bursts of back-to-back items with random gaps between bursts
  task automatic send_item(req_item_t item);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_item(make_item(OP_TICK, 0, 0, 0));          // all slots idle
    send_item(make_item(OP_DISPATCH, 0, 0, 0));      // nothing ready
    send_item(make_item(OP_ADD, 255, 0, 1));         // slot checked before period
    send_item(make_item(OP_ADD, 8, 5, 1));
    send_item(make_item(OP_ADD, 0, 0, 1));           // zero period
    send_item(make_item(OP_CLEAR, 8, 0, 0));
    send_item(make_item(OP_CLEAR, 255, 32767, 1));
    send_item(make_item(OP_ADD, 0, 1, 1));
    send_item(make_item(OP_ADD, 7, 32767, 1));
    send_item(make_item(OP_ADD, 3, 2, 0));           // no handler
    send_item(make_item(OP_ADD, 5, 1, 1));
    send_item(make_item(OP_TICK, 0, 0, 0));
    send_item(make_item(OP_DISPATCH, 0, 0, 0));
    send_item(make_item(OP_DISPATCH, 0, 0, 0));
    send_item(make_item(OP_DISPATCH, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0));          // slot 3 ready without handler
    send_item(make_item(OP_DISPATCH, 0, 0, 0));
    send_item(make_item(OP_CLEAR, 5, 0, 0));         // ready slot dropped, keeps counting
    send_item(make_item(OP_DISPATCH, 0, 0, 0));
    send_item(make_item(OP_TICK, 0, 0, 0));
    send_item(make_item(OP_ADD, 0, 3, 1));           // re-add drops the pending release
    send_item(make_item(OP_DISPATCH, 0, 0, 0));
    send_item(make_item(OP_ADD, 6, 21845, 0));
    send_item(make_item(OP_ADD, 4, 10922, 1));
    send_item(make_item(OP_CLEAR, 1, 0, 0));         // clear of an idle slot
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  task automatic test_full_range_fields(int count);
    for (int i = 0; i < count; i++) begin
      send_item(make_item(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                          $urandom_range(0, 32767), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_output_backpressure(int count);
    hold_req = 1'b1;
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic(200);
    test_output_backpressure(40);
    test_full_range_fields(60);
    test_random_traffic(230);
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
